// ===== hdl/dte_pkg.sv =====
// Shared types and constants for the RTC date to epoch-seconds converter.
// Used by hdl/rtc_date_to_epoch_seconds.sv. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dte_pkg;

    localparam int unsigned EpochYear  = 1970;
    localparam int unsigned YearMin    = 2000;
    localparam int unsigned YearMax    = 2100;
    localparam int unsigned SecsPerDay = 86400;
    localparam int unsigned SecsPerHr  = 3600;
    localparam int unsigned SecsPerMin = 60;
    localparam int unsigned DaysLeap   = 366;
    localparam int unsigned DaysNorm   = 365;

    // Fallback date for a reading that fails the range checks
    localparam int unsigned DefYear  = 2024;
    localparam int unsigned DefMonth = 4;
    localparam int unsigned DefDay   = 18;
    localparam int unsigned DefHour  = 12;

    // Year mod 100 and mod 400 for the epoch year, seeds for the leap counters
    localparam int unsigned EpochMod100 = EpochYear % 100;
    localparam int unsigned EpochMod400 = EpochYear % 400;

    typedef struct packed {
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [7:0] hours;
        logic [7:0] day_of_month;
        logic [7:0] month_number;
        logic [7:0] year_in_century;
        logic [7:0] century_number;
    } req_t;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        used_default;
    } res_t;

    // Days in month, index 0 = January, February without the leap day
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd1:    d = 5'd28;
            4'd3:    d = 5'd30;
            4'd5:    d = 5'd30;
            4'd8:    d = 5'd30;
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rtc_date_to_epoch_seconds.sv =====
// RTC date to Unix epoch seconds converter, top level.
// Depends on hdl/dte_pkg.sv.
`timescale 1ns / 1ps
`default_nettype none

// Takes one binary clock reading per request and returns one result: the
// seconds since 1970-01-01 00:00:00 (Gregorian leap years) and a flag that
// is set when the reading was out of range and 2024-04-18 12:00:00 was used
// instead. The block works on one request at a time and holds req_stall high
// while busy, and the next request can be taken in the same cycle that the
// result becomes valid. One adder walks the years one per cycle, keeping
// year mod 100 and mod 400 in counters for the leap rule, then the months
// one per cycle, then adds the day of month; a multiply state then forms
// the days times 86400 and the time of day, and a last add sums the two.
// The result sits in an output register, so a stall on the result side only
// holds the block once the next result is ready.
module rtc_date_to_epoch_seconds
    import dte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_YEAR  = 3'd2;
    localparam logic [2:0] ST_MONTH = 3'd3;
    localparam logic [2:0] ST_DAY   = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_SUM   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic        res_valid_reg, res_valid_next;

    req_t        in_reg, in_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hr_reg, hr_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic        bad_reg, bad_next;
    logic [11:0] y_reg, y_next;
    logic [6:0]  c100_reg, c100_next;
    logic [8:0]  c400_reg, c400_next;
    logic [3:0]  m_reg, m_next;
    logic [15:0] days_reg, days_next;
    logic [31:0] prod_reg, prod_next;
    logic [16:0] tod_reg, tod_next;
    res_t        res_reg, res_next;

    logic [14:0] full_year;
    logic        bad;
    logic        leap;

    assign full_year = 15'(in_reg.century_number) * 15'(100) + 15'(in_reg.year_in_century);

    assign bad = (full_year < 15'(YearMin)) || (full_year > 15'(YearMax)) ||
                 (in_reg.month_number < 8'd1) || (in_reg.month_number > 8'd12) ||
                 (in_reg.day_of_month < 8'd1) || (in_reg.day_of_month > 8'd31) ||
                 (in_reg.hours > 8'd23) || (in_reg.minutes > 8'd59) ||
                 (in_reg.seconds > 8'd59);

    // Leap rule for the year held in y_reg
    assign leap = ((y_reg[1:0] == 2'd0) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        in_next        = in_reg;
        year_next      = year_reg;
        mon_next       = mon_reg;
        day_next       = day_reg;
        hr_next        = hr_reg;
        min_next       = min_reg;
        sec_next       = sec_reg;
        bad_next       = bad_reg;
        y_next         = y_reg;
        c100_next      = c100_reg;
        c400_next      = c400_reg;
        m_next         = m_reg;
        days_next      = days_reg;
        prod_next      = prod_reg;
        tod_next       = tod_reg;
        res_next       = res_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    in_next    = req_data;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                bad_next  = bad;
                if (bad)
                begin
                    year_next = 12'(DefYear);
                    mon_next  = 4'(DefMonth);
                    day_next  = 5'(DefDay);
                    hr_next   = 5'(DefHour);
                    min_next  = 6'd0;
                    sec_next  = 6'd0;
                end
                else
                begin
                    year_next = full_year[11:0];
                    mon_next  = in_reg.month_number[3:0];
                    day_next  = in_reg.day_of_month[4:0];
                    hr_next   = in_reg.hours[4:0];
                    min_next  = in_reg.minutes[5:0];
                    sec_next  = in_reg.seconds[5:0];
                end
                y_next     = 12'(EpochYear);
                c100_next  = 7'(EpochMod100);
                c400_next  = 9'(EpochMod400);
                days_next  = 16'd0;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                if (y_reg < year_reg)
                begin
                    days_next = days_reg + (leap ? 16'(DaysLeap) : 16'(DaysNorm));
                    y_next    = y_reg + 12'd1;
                    c100_next = (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
                else
                begin
                    m_next     = 4'd0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                // y_reg now equals the target year, so leap applies to it
                if ({1'b0, m_reg} + 5'd1 < {1'b0, mon_reg})
                begin
                    days_next = days_reg + 16'(month_days(m_reg)) +
                                16'((m_reg == 4'd1) && leap);
                    m_next    = m_reg + 4'd1;
                end
                else
                begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                days_next  = days_reg + 16'(day_reg) - 16'd1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = 32'(days_reg) * 32'(SecsPerDay);
                tod_next   = 17'(hr_reg) * 17'(SecsPerHr) + 17'(min_reg) * 17'(SecsPerMin) +
                             17'(sec_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.epoch_seconds = prod_reg + 32'(tod_reg);
                    res_next.used_default  = bad_reg;
                    res_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        year_reg <= year_next;
        mon_reg  <= mon_next;
        day_reg  <= day_next;
        hr_reg   <= hr_next;
        min_reg  <= min_next;
        sec_reg  <= sec_next;
        bad_reg  <= bad_next;
        y_reg    <= y_next;
        c100_reg <= c100_next;
        c400_reg <= c400_next;
        m_reg    <= m_next;
        days_reg <= days_next;
        prod_reg <= prod_next;
        tod_reg  <= tod_next;
        res_reg  <= res_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

`default_nettype wire
